// File: hdl/mfd_pkg.sv
package mfd_pkg;

  // Start-of-frame marker.
  localparam logic [7:0] START_BYTE = 8'h40;

  // Idle ticks allowed while hunting, after reset.
  localparam logic [15:0] WAIT_LIMIT_RST = 16'd1000;

  // Input word opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Where the deframer stands within a frame.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_XID     = 4'd1,
    PH_TYPE    = 4'd2,
    PH_COUNT   = 4'd3,
    PH_SUBSYS  = 4'd4,
    PH_FIELD   = 4'd5,
    PH_LENHI   = 4'd6,
    PH_LENLO   = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_t;

  // Classification of one reported byte.
  typedef enum logic [3:0] {
    KIND_START   = 4'd0,
    KIND_XID     = 4'd1,
    KIND_TYPE    = 4'd2,
    KIND_COUNT   = 4'd3,
    KIND_SUBSYS  = 4'd4,
    KIND_FIELD   = 4'd5,
    KIND_LENHI   = 4'd6,
    KIND_LENLO   = 4'd7,
    KIND_PAYLOAD = 4'd8
  } kind_t;

  // Error reported with a word.
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TIMEOUT = 2'd1,
    ERR_COUNT   = 2'd2,
    ERR_LENGTH  = 2'd3
  } err_t;

endpackage

// File: hdl/mfd_if.sv
// Input channel: received bytes and idle ticks.
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// Output channel: classified frame bytes and error reports.
interface mfd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] value;
  logic [3:0] param_index;
  logic       frame_last;
  logic [1:0] error_code;

  modport source (output valid, output kind, output value, output param_index,
                  output frame_last, output error_code, input ready);
  modport sink   (input valid, input kind, input value, input param_index,
                  input frame_last, input error_code, output ready);
endinterface

// File: hdl/modem_frame_deframer.sv
// A word accepted at a clock edge has its result word, if any, loaded into the output register at that edge.
// Throughput: one input word per cycle, set by the frame state machine
// feeding one output register; input stalls only while that register is held.
// Reset (rst, synchronous, active high) returns the deframer to hunting for the
// start byte, clears all counters, drops the output and sets wait_limit to 1000.
module modem_frame_deframer #(
  parameter int MAX_PARAMS  = 16,
  parameter int MAX_MSG_LEN = 256
) (
  input  logic        clk,
  input  logic        rst,
  mfd_in_if.sink      rx,
  mfd_out_if.source   res,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import mfd_pkg::*;

  localparam int PW = $clog2(MAX_PARAMS + 1);
  localparam int LW = $clog2(MAX_MSG_LEN + 1);
  localparam logic [8:0]  MaxParamsC = 9'(MAX_PARAMS);
  localparam logic [16:0] MaxLenC    = 17'(MAX_MSG_LEN);

  // Frame state.
  phase_t        phase, phase_next;
  logic [PW-1:0] params_left, params_left_next;
  logic [3:0]    current_param, current_param_next;
  logic [LW-1:0] payload_left, payload_left_next;
  logic [7:0]    length_high, length_high_next;
  logic [15:0]   idle_ticks, idle_ticks_next;
  logic [15:0]   wait_limit;

  // Result of the word being accepted.
  logic       emit;
  kind_t      kind_next;
  logic [3:0] pidx_next;
  logic       last_next;
  err_t       err_next;

  logic        accept;
  logic [15:0] len;
  logic        param_done;

  assign rx.ready = !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;
  assign len      = {length_high, rx.rx_byte};
  assign param_done = (params_left <= PW'(1));

  // Next state and result for one word.
  always_comb begin
    phase_next         = phase;
    params_left_next   = params_left;
    current_param_next = current_param;
    payload_left_next  = payload_left;
    length_high_next   = length_high;
    idle_ticks_next    = idle_ticks;
    emit      = 1'b0;
    kind_next = KIND_START;
    pidx_next = current_param;
    last_next = 1'b0;
    err_next  = ERR_NONE;

    if (rx.opcode == OP_TICK) begin
      // Idle ticks only count while hunting.
      if (phase == PH_HUNT) begin
        if (idle_ticks >= wait_limit) begin
          idle_ticks_next = '0;
          emit      = 1'b1;
          pidx_next = '0;
          err_next  = ERR_TIMEOUT;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
    end else begin
      case (phase)
        PH_XID: begin
          phase_next = PH_TYPE;
          emit       = 1'b1;
          kind_next  = KIND_XID;
          pidx_next  = '0;
        end
        PH_TYPE: begin
          phase_next = PH_COUNT;
          emit       = 1'b1;
          kind_next  = KIND_TYPE;
          pidx_next  = '0;
        end
        PH_COUNT: begin
          current_param_next = '0;
          emit      = 1'b1;
          kind_next = KIND_COUNT;
          pidx_next = '0;
          if ({1'b0, rx.rx_byte} > MaxParamsC) begin
            phase_next       = PH_HUNT;
            params_left_next = '0;
            err_next         = ERR_COUNT;
          end else if (rx.rx_byte == 8'd0) begin
            phase_next       = PH_HUNT;
            params_left_next = '0;
            last_next        = 1'b1;
          end else begin
            params_left_next = PW'(rx.rx_byte);
            phase_next       = PH_SUBSYS;
          end
        end
        PH_SUBSYS: begin
          phase_next = PH_FIELD;
          emit       = 1'b1;
          kind_next  = KIND_SUBSYS;
        end
        PH_FIELD: begin
          phase_next = PH_LENHI;
          emit       = 1'b1;
          kind_next  = KIND_FIELD;
        end
        PH_LENHI: begin
          length_high_next = rx.rx_byte;
          phase_next       = PH_LENLO;
          emit             = 1'b1;
          kind_next        = KIND_LENHI;
        end
        PH_LENLO: begin
          emit      = 1'b1;
          kind_next = KIND_LENLO;
          if ({1'b0, len} > MaxLenC) begin
            phase_next         = PH_HUNT;
            params_left_next   = '0;
            current_param_next = '0;
            err_next           = ERR_LENGTH;
          end else if (len == 16'd0) begin
            // Empty parameter: it ends here.
            last_next = param_done;
            if (params_left != '0) params_left_next = params_left - PW'(1);
            if (param_done) begin
              phase_next         = PH_HUNT;
              current_param_next = '0;
            end else begin
              phase_next         = PH_SUBSYS;
              current_param_next = current_param + 4'd1;
            end
          end else begin
            payload_left_next = LW'(len);
            phase_next        = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          emit      = 1'b1;
          kind_next = KIND_PAYLOAD;
          if (payload_left != '0) payload_left_next = payload_left - LW'(1);
          if (payload_left <= LW'(1)) begin
            // Last payload byte closes the parameter.
            last_next = param_done;
            if (params_left != '0) params_left_next = params_left - PW'(1);
            if (param_done) begin
              phase_next         = PH_HUNT;
              current_param_next = '0;
            end else begin
              phase_next         = PH_SUBSYS;
              current_param_next = current_param + 4'd1;
            end
          end
        end
        default: begin
          // Hunting: only the start byte opens a frame.
          phase_next = PH_HUNT;
          if (rx.rx_byte == START_BYTE) begin
            idle_ticks_next = '0;
            phase_next      = PH_XID;
            emit            = 1'b1;
            kind_next       = KIND_START;
            pidx_next       = '0;
          end
        end
      endcase
    end
  end

  // Frame state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      params_left   <= '0;
      current_param <= '0;
      payload_left  <= '0;
      length_high   <= '0;
      idle_ticks    <= '0;
      wait_limit    <= WAIT_LIMIT_RST;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        params_left   <= params_left_next;
        current_param <= current_param_next;
        payload_left  <= payload_left_next;
        length_high   <= length_high_next;
        idle_ticks    <= idle_ticks_next;
      end
      if (cfg_we) wait_limit <= cfg_wdata;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= emit;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.kind        <= kind_next;
      res.value       <= (err_next == ERR_TIMEOUT) ? 8'd0 : rx.rx_byte;
      res.param_index <= pidx_next;
      res.frame_last  <= last_next;
      res.error_code  <= err_next;
    end
  end

`ifndef SYNTH
  // A word that ends a frame or reports an error leaves the deframer hunting.
  a_end_hunts: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.frame_last || res.error_code != ERR_NONE)) |-> (phase == PH_HUNT))
    else $error("deframer not hunting after frame end or error");

  // Inside the parameter section at least one parameter is still open.
  a_params_open: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUBSYS || phase == PH_FIELD || phase == PH_LENHI ||
     phase == PH_LENLO || phase == PH_PAYLOAD) |-> (params_left != '0))
    else $error("parameter section entered with no parameters left");

  // Payload phase always has bytes left to take.
  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_left != '0))
    else $error("payload phase with zero bytes left");

  // A frame end word never carries an error.
  a_last_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_last) |-> (res.error_code == ERR_NONE))
    else $error("frame end word carries an error");
`endif

endmodule

// File: test/modem_frame_deframer_tb.sv
module modem_frame_deframer_tb;
  import mfd_pkg::*;

  localparam int MAX_PARAMS    = 16;
  localparam int MAX_MSG_LEN   = 256;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_LIMIT   = 100;

  // One classified word as it leaves the deframer.
  typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic [3:0] param_index;
    logic       frame_last;
    err_t       error_code;
  } frame_word_t;

  // Tracks the frame state of the deframer and holds the words it must produce.
  class deframe_scoreboard;
    phase_t      phase;
    logic [4:0]  params_left;
    logic [3:0]  current_param;
    logic [15:0] payload_left;
    logic [7:0]  length_high;
    logic [15:0] idle_ticks;
    logic [15:0] wait_limit;
    frame_word_t expected_words[$];
    int          mismatches;

    function new();
      phase         = PH_HUNT;
      params_left   = '0;
      current_param = '0;
      payload_left  = '0;
      length_high   = '0;
      idle_ticks    = '0;
      wait_limit    = WAIT_LIMIT_RST;
      mismatches    = 0;
    endfunction

    function void set_wait_limit(logic [15:0] v);
      wait_limit = v;
    endfunction

    function void push(kind_t k, logic [7:0] v, logic [3:0] p, logic l, err_t e);
      frame_word_t w;
      w.kind        = k;
      w.value       = v;
      w.param_index = p;
      w.frame_last  = l;
      w.error_code  = e;
      expected_words.push_back(w);
    endfunction

    // Closes one parameter; returns 1 when it was the last of the frame.
    function logic close_param();
      if (params_left != 0) params_left--;
      if (params_left == 0) begin
        phase         = PH_HUNT;
        current_param = '0;
        return 1'b1;
      end
      current_param++;
      phase = PH_SUBSYS;
      return 1'b0;
    endfunction

    // Advances the frame state by one accepted input word.
    function void note_word(logic op, logic [7:0] b);
      logic [3:0]  pidx;
      logic [15:0] len;
      logic        last;
      pidx = current_param;
      if (op == OP_TICK) begin
        if (phase != PH_HUNT) return;
        if (idle_ticks >= wait_limit) begin
          idle_ticks = '0;
          push(KIND_START, 8'h00, 4'd0, 1'b0, ERR_TIMEOUT);
        end else begin
          idle_ticks++;
        end
        return;
      end
      case (phase)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            idle_ticks = '0;
            phase      = PH_XID;
            push(KIND_START, b, 4'd0, 1'b0, ERR_NONE);
          end
        end
        PH_XID: begin
          phase = PH_TYPE;
          push(KIND_XID, b, 4'd0, 1'b0, ERR_NONE);
        end
        PH_TYPE: begin
          phase = PH_COUNT;
          push(KIND_TYPE, b, 4'd0, 1'b0, ERR_NONE);
        end
        PH_COUNT: begin
          current_param = '0;
          if (b > MAX_PARAMS) begin
            phase       = PH_HUNT;
            params_left = '0;
            push(KIND_COUNT, b, 4'd0, 1'b0, ERR_COUNT);
          end else if (b == 0) begin
            phase       = PH_HUNT;
            params_left = '0;
            push(KIND_COUNT, b, 4'd0, 1'b1, ERR_NONE);
          end else begin
            params_left = b[4:0];
            phase       = PH_SUBSYS;
            push(KIND_COUNT, b, 4'd0, 1'b0, ERR_NONE);
          end
        end
        PH_SUBSYS: begin
          phase = PH_FIELD;
          push(KIND_SUBSYS, b, pidx, 1'b0, ERR_NONE);
        end
        PH_FIELD: begin
          phase = PH_LENHI;
          push(KIND_FIELD, b, pidx, 1'b0, ERR_NONE);
        end
        PH_LENHI: begin
          length_high = b;
          phase       = PH_LENLO;
          push(KIND_LENHI, b, pidx, 1'b0, ERR_NONE);
        end
        PH_LENLO: begin
          len = {length_high, b};
          if (len > MAX_MSG_LEN) begin
            phase         = PH_HUNT;
            params_left   = '0;
            current_param = '0;
            push(KIND_LENLO, b, pidx, 1'b0, ERR_LENGTH);
          end else if (len == 0) begin
            last = close_param();
            push(KIND_LENLO, b, pidx, last, ERR_NONE);
          end else begin
            payload_left = len;
            phase        = PH_PAYLOAD;
            push(KIND_LENLO, b, pidx, 1'b0, ERR_NONE);
          end
        end
        default: begin
          last = 1'b0;
          if (payload_left != 0) payload_left--;
          if (payload_left == 0) last = close_param();
          push(KIND_PAYLOAD, b, pidx, last, ERR_NONE);
        end
      endcase
    endfunction

    // Output is capped so a badly broken block cannot flood the log.
    task report(string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Compares one delivered word with the oldest outstanding one.
    task check_word(frame_word_t got);
      frame_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d value %02h", got.kind, got.value));
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("value got %02h want %02h", got.value, want.value));
      if (got.param_index !== want.param_index)
        report($sformatf("param_index got %0d want %0d", got.param_index, want.param_index));
      if (got.frame_last !== want.frame_last)
        report($sformatf("frame_last got %b want %b", got.frame_last, want.frame_last));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code got %0d want %0d", got.error_code, want.error_code));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  mfd_in_if  rx_if ();
  mfd_out_if res_if ();

  deframe_scoreboard sb;
  frame_word_t       seen_word;
  int                in_idle_pct  = 38;
  int                out_idle_pct = 48;
  int                words_sent   = 0;
  int                stall_cycles = 0;

  modem_frame_deframer #(
    .MAX_PARAMS  (MAX_PARAMS),
    .MAX_MSG_LEN (MAX_MSG_LEN)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random according to the current idle share.
  always @(posedge clk) begin
    res_if.ready <= (out_idle_pct == 0) || ($urandom_range(99) >= out_idle_pct);
  end

  // Watch both channels; results are checked before the same edge's input is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        seen_word.kind        = kind_t'(res_if.kind);
        seen_word.value       = res_if.value;
        seen_word.param_index = res_if.param_index;
        seen_word.frame_last  = res_if.frame_last;
        seen_word.error_code  = err_t'(res_if.error_code);
        sb.check_word(seen_word);
      end
      if (rx_if.valid && rx_if.ready) sb.note_word(rx_if.opcode, rx_if.rx_byte);
      if ((res_if.valid && res_if.ready) || (rx_if.valid && rx_if.ready) || cfg_we)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // The run is abandoned when nothing moves for too long.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("modem_frame_deframer verification failed");
    $finish;
  end

  // Offers one input word, with a random gap before it, and waits for acceptance.
  task automatic send_word(input logic op, input logic [7:0] b);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.opcode  <= op;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    words_sent++;
  endtask

  // A frame byte, sometimes preceded by an idle tick.
  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(19) == 0) send_word(OP_TICK, 8'($urandom_range(255)));
    send_word(OP_BYTE, b);
  endtask

  // Waits until every outstanding word has been delivered and the block is quiet.
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_wait_limit(input logic [15:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_wait_limit(v);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 0;
    if (r < 92) return $urandom_range(1, 6);
    if (r < 98) return $urandom_range(7, 40);
    return $urandom_range(MAX_MSG_LEN - 8, MAX_MSG_LEN);
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, MAX_PARAMS);
  endfunction

  // Sends a frame. A parameter numbered bad_param gets an oversize length and
  // ends the frame; a fixed_len of zero or more replaces the random lengths.
  task automatic send_frame(input int count, input int bad_param, input int fixed_len);
    int len;
    frame_byte(START_BYTE);
    frame_byte(8'($urandom_range(255)));
    frame_byte(8'($urandom_range(255)));
    frame_byte(8'(count));
    if (count > MAX_PARAMS) return;
    for (int p = 0; p < count; p++) begin
      frame_byte(8'($urandom_range(255)));
      frame_byte(8'($urandom_range(255)));
      if (p == bad_param) len = $urandom_range(MAX_MSG_LEN + 1, 65535);
      else if (fixed_len >= 0) len = fixed_len;
      else len = pick_length();
      frame_byte(len[15:8]);
      frame_byte(len[7:0]);
      if (p == bad_param) return;
      repeat (len) frame_byte(8'($urandom_range(255)));
    end
  endtask

  // Mostly well-formed frames, mixed with broken ones, tick bursts and noise.
  task automatic run_traffic(input int n);
    int stop_at;
    int r;
    int cnt;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_frame(pick_count(), -1, -1);
      end else if (r < 63) begin
        // A frame cut short; its successor is read as continuation data.
        frame_byte(START_BYTE);
        repeat ($urandom_range(0, 8)) frame_byte(8'($urandom_range(255)));
      end else if (r < 71) begin
        send_frame($urandom_range(MAX_PARAMS + 1, 255), -1, -1);
      end else if (r < 79) begin
        cnt = $urandom_range(1, 4);
        send_frame(cnt, $urandom_range(0, cnt - 1), -1);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 12)) send_word(OP_TICK, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(OP_BYTE, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_directed();
    // Noise and a tick while hunting produce nothing.
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'hFF);
    // A count of zero closes the frame on the count byte.
    send_word(OP_BYTE, START_BYTE);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
    // One parameter too many.
    send_word(OP_BYTE, START_BYTE);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'd17);
    // Length one past the maximum.
    send_word(OP_BYTE, START_BYTE);
    send_word(OP_BYTE, 8'h55);
    send_word(OP_BYTE, 8'hAA);
    send_word(OP_BYTE, 8'd1);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_BYTE, 8'h01);
    // Zero length on the only parameter, with an ignored tick inside the frame.
    send_word(OP_BYTE, START_BYTE);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_BYTE, 8'h02);
    send_word(OP_BYTE, 8'd1);
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
  endtask

  initial begin
    sb = new();
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.opcode  <= OP_BYTE;
    rx_if.rx_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 16'h0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender and receiver both idle, wait limit still at its reset value.
    run_directed();
    send_frame(MAX_PARAMS, -1, 0);
    send_frame(1, -1, MAX_MSG_LEN);
    run_traffic(150);
    write_wait_limit(16'd5);
    run_traffic(150);

    // Idle shares swapped; every tick while hunting times out at first.
    in_idle_pct  = 48;
    out_idle_pct = 38;
    write_wait_limit(16'd0);
    run_traffic(200);
    write_wait_limit(16'($urandom_range(1, 30)));
    run_traffic(150);

    // No idling: with the largest limit a short tick burst never times out.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_wait_limit(16'hFFFF);
    repeat (40) send_word(OP_TICK, 8'($urandom_range(255)));
    write_wait_limit(16'd3);
    run_traffic(150);

    drain_results();
    if (sb.mismatches == 0)
      $display("modem_frame_deframer verification clean");
    else
      $display("modem_frame_deframer verification failed");
    $finish;
  end

endmodule

// File: files.f
hdl/mfd_pkg.sv
hdl/mfd_if.sv
hdl/modem_frame_deframer.sv
test/modem_frame_deframer_tb.sv
